FILE: design/pcxrle_pkg.sv
`default_nettype none

package pcxrle_pkg;

  localparam int unsigned SIDE_W  = 10;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RGB_W   = 24;

  // input opcodes, carried in tuser
  localparam logic [1:0] OP_DATA    = 2'd0;
  localparam logic [1:0] OP_PALETTE = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;

  localparam logic [BYTE_W-1:0] RUN_MARK    = 8'hC0;
  localparam logic [BYTE_W-1:0] RUN_MASK    = 8'h3F;
  localparam logic [BYTE_W-1:0] CLEAR_INDEX = 8'hFF;
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [BYTE_W-1:0] ALPHA_CLEAR  = 8'h00;

  // configuration register indexes
  localparam logic CFG_LAST_COLUMN = 1'b0;
  localparam logic CFG_LAST_ROW    = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_START,
    CMD_EMIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [BYTE_W-1:0]   index;
    logic [COUNT_W-1:0]  count;
    logic [RGB_W-1:0]    rgb;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] color_index;
    logic              last_of_run;
    logic              end_of_row;
    logic              end_of_image;
  } pixel_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/pcx_rle_palette_decoder_unit.sv
`default_nettype none

// PCX 8-bit run-length decoder with a palette lookup, producing one RGBA pixel per
// output item. Input tuser carries the opcode (data byte, palette write, start of
// image); the last_column/last_row registers set the image size, and the user must
// write them through the cfg port only while the block is idle, which the block
// itself does not enforce. A run header produces nothing; the front end holds its
// count until the value byte arrives. Every other data, palette or start item
// becomes a command in a two-entry queue. The back end takes a command in its idle
// state, then for a pixel run reads the palette RAM in its lookup state and emits
// one pixel per cycle in its emit state while the output is not stalled, each held
// in a one-pixel output register. Pixels past the end of the row are dropped, and
// data after the final pixel is ignored until the next start.
module pcx_rle_palette_decoder_unit #(
  parameter int unsigned MAX_SIDE        = 1024,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // data_byte, palette_index, palette_red, palette_green, palette_blue
  input  wire logic [39:0] s_axis_tdata,
  // opcode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // red, green, blue, alpha, color_index
  output logic [39:0]      m_axis_tdata,
  // last_of_run
  output logic             m_axis_tlast,
  // end_of_row, end_of_image
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);

  logic [pcxrle_pkg::SIDE_W-1:0] last_column;
  logic [pcxrle_pkg::SIDE_W-1:0] last_row;

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  pcxrle_pkg::cmd_t   q_in;
  pcxrle_pkg::cmd_t   q_head;
  pcxrle_pkg::pixel_t pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_column <= '0;
      last_row    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcxrle_pkg::CFG_LAST_COLUMN: last_column <= cfg_data;
        pcxrle_pkg::CFG_LAST_ROW:    last_row    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pcxrle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .opcode        (s_axis_tuser),
    .data_byte     (s_axis_tdata[7:0]),
    .palette_index (s_axis_tdata[15:8]),
    .palette_rgb   ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in)
  );

  pcxrle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  pcxrle_back #(
    .MAX_SIDE        (MAX_SIDE),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .last_column (last_column),
    .last_row    (last_row),
    .cmd_valid   (!q_empty),
    .cmd         (q_head),
    .cmd_pop     (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_pixel   (pixel)
  );

  assign m_axis_tdata = {pixel.color_index, pixel.alpha, pixel.blue, pixel.green, pixel.red};
  assign m_axis_tlast = pixel.last_of_run;
  assign m_axis_tuser = {pixel.end_of_image, pixel.end_of_row};

  // the front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command pushed into full queue");

  // the back end never takes from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("command popped from empty queue");

  // the final pixel of an image closes its row and its run
  a_image_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && m_axis_tlast))
    else $error("end of image without end of row and run");

  // transparent alpha goes with the clear index only
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tdata[31:24] == 8'h00) == (m_axis_tdata[39:32] == 8'hFF)))
    else $error("alpha does not match color index");

endmodule

`default_nettype wire

FILE: design/pcxrle_ram.sv
`default_nettype none

module pcxrle_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/pcxrle_queue.sv
`default_nettype none

// two-entry command queue between front and back
module pcxrle_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire pcxrle_pkg::cmd_t   push_cmd,
  input  wire logic               pop,
  output logic                    full,
  output logic                    empty,
  output pcxrle_pkg::cmd_t        head
);

  pcxrle_pkg::cmd_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       used;
  logic             do_push;
  logic             do_pop;

  assign full    = (used == 2'd2);
  assign empty   = (used == 2'd0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        used <= used + 2'd1;
      end else if (do_pop && !do_push) begin
        used <= used - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: design/pcxrle_front.sv
`default_nettype none

// Accepts input items, tracks run headers and turns every other data, palette or start item into a command.
module pcxrle_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         opcode,
  input  wire logic [pcxrle_pkg::BYTE_W-1:0]      data_byte,
  input  wire logic [pcxrle_pkg::BYTE_W-1:0]      palette_index,
  input  wire logic [pcxrle_pkg::RGB_W-1:0]       palette_rgb,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output pcxrle_pkg::cmd_t                        q_cmd
);

  logic                               awaiting;
  logic                               awaiting_next;
  logic [pcxrle_pkg::COUNT_W-1:0]     pending;
  logic [pcxrle_pkg::COUNT_W-1:0]     pending_next;
  logic                               accept;
  logic                               is_header;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_header = ((data_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK);

  always_comb begin
    awaiting_next = awaiting;
    pending_next  = pending;
    q_push        = 1'b0;
    q_cmd.kind    = pcxrle_pkg::CMD_EMIT;
    q_cmd.index   = data_byte;
    q_cmd.count   = pcxrle_pkg::COUNT_W'(1);
    q_cmd.rgb     = palette_rgb;
    if (accept) begin
      case (opcode)
        pcxrle_pkg::OP_DATA: begin
          if (awaiting) begin
            q_push        = 1'b1;
            q_cmd.count   = pending;
            awaiting_next = 1'b0;
            pending_next  = '0;
          end else if (is_header) begin
            awaiting_next = 1'b1;
            pending_next  = pcxrle_pkg::COUNT_W'(data_byte & pcxrle_pkg::RUN_MASK);
          end else begin
            q_push = 1'b1;
          end
        end
        pcxrle_pkg::OP_PALETTE: begin
          q_push      = 1'b1;
          q_cmd.kind  = pcxrle_pkg::CMD_WRITE;
          q_cmd.index = palette_index;
        end
        pcxrle_pkg::OP_START: begin
          q_push        = 1'b1;
          q_cmd.kind    = pcxrle_pkg::CMD_START;
          awaiting_next = 1'b0;
          pending_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting <= 1'b0;
      pending  <= '0;
    end else begin
      awaiting <= awaiting_next;
      pending  <= pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/pcxrle_back.sv
`default_nettype none

// Executes commands: palette writes, image restarts and pixel runs.
module pcxrle_back #(
  parameter int unsigned MAX_SIDE        = 1024,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [pcxrle_pkg::SIDE_W-1:0]  last_column,
  input  wire logic [pcxrle_pkg::SIDE_W-1:0]  last_row,
  input  wire logic                           cmd_valid,
  input  wire pcxrle_pkg::cmd_t               cmd,
  output logic                                cmd_pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output pcxrle_pkg::pixel_t                  out_pixel
);

  localparam int unsigned SW       = pcxrle_pkg::SIDE_W;
  localparam int unsigned CW       = pcxrle_pkg::COUNT_W;
  localparam int unsigned AW       = $clog2(PALETTE_ENTRIES);
  localparam int unsigned SIDE_MAX = MAX_SIDE - 1;

  pcxrle_pkg::back_state_t state;
  pcxrle_pkg::back_state_t state_next;

  logic [SW-1:0]                     col;
  logic [SW-1:0]                     row;
  logic                              complete;
  logic [CW-1:0]                     cur_count;
  logic [pcxrle_pkg::BYTE_W-1:0]     cur_index;
  logic [pcxrle_pkg::RGB_W-1:0]      colour;
  logic                              rd_in_range;
  logic [pcxrle_pkg::RGB_W-1:0]      rd_data;

  logic [SW-1:0]                     lc;
  logic [SW-1:0]                     lr;
  logic                              cmd_in_range;
  logic                              out_free;
  logic                              ram_we;
  logic                              start_clear;
  logic                              capture;
  logic                              emit_step;
  logic                              row_end;
  logic                              img_end;
  logic [CW-1:0]                     cnt_left;
  logic                              run_last;
  pcxrle_pkg::pixel_t                pix_next;

  // registers above the supported side read as the largest side
  assign lc = (32'(last_column) > SIDE_MAX) ? SW'(SIDE_MAX) : last_column;
  assign lr = (32'(last_row) > SIDE_MAX) ? SW'(SIDE_MAX) : last_row;

  assign cmd_in_range = (32'(cmd.index) < PALETTE_ENTRIES);
  assign out_free     = !out_valid || out_ready;

  pcxrle_ram #(
    .WIDTH (pcxrle_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.index[AW-1:0]),
    .wdata (cmd.rgb),
    .raddr (cmd.index[AW-1:0]),
    .rdata (rd_data)
  );

  // pixel at the current position
  assign row_end  = (col >= lc);
  assign img_end  = row_end && (row >= lr);
  assign cnt_left = cur_count - CW'(1);
  assign run_last = (cnt_left == '0) || row_end;

  always_comb begin
    pix_next.red          = colour[23:16];
    pix_next.green        = colour[15:8];
    pix_next.blue         = colour[7:0];
    pix_next.alpha        = (cur_index == pcxrle_pkg::CLEAR_INDEX) ?
                            pcxrle_pkg::ALPHA_CLEAR : pcxrle_pkg::ALPHA_OPAQUE;
    pix_next.color_index  = cur_index;
    pix_next.last_of_run  = run_last;
    pix_next.end_of_row   = row_end;
    pix_next.end_of_image = img_end;
  end

  always_comb begin
    state_next = state;
    case (state)
      pcxrle_pkg::BK_IDLE: begin
        if (cmd_valid && cmd.kind == pcxrle_pkg::CMD_EMIT &&
            cmd.count != '0 && !complete) begin
          state_next = pcxrle_pkg::BK_LOOKUP;
        end
      end
      pcxrle_pkg::BK_LOOKUP: begin
        state_next = pcxrle_pkg::BK_EMIT;
      end
      pcxrle_pkg::BK_EMIT: begin
        if (out_free && run_last) begin
          state_next = pcxrle_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = pcxrle_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    start_clear = 1'b0;
    capture     = 1'b0;
    emit_step   = 1'b0;
    case (state)
      pcxrle_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid;
        capture = cmd_valid;
        if (cmd_valid) begin
          case (cmd.kind)
            pcxrle_pkg::CMD_WRITE: ram_we = cmd_in_range;
            pcxrle_pkg::CMD_START: start_clear = 1'b1;
            default: begin
            end
          endcase
        end
      end
      pcxrle_pkg::BK_EMIT: begin
        emit_step = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcxrle_pkg::BK_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
      complete  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (start_clear) begin
        col      <= '0;
        row      <= '0;
        complete <= 1'b0;
      end else if (emit_step) begin
        if (row_end) begin
          col <= '0;
          if (img_end) begin
            complete <= 1'b1;
          end else begin
            row <= row + SW'(1);
          end
        end else begin
          col <= col + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      cur_index   <= cmd.index;
      cur_count   <= cmd.count;
      rd_in_range <= cmd_in_range;
    end else if (emit_step) begin
      cur_count <= cnt_left;
    end
    if (state == pcxrle_pkg::BK_LOOKUP) begin
      colour <= rd_in_range ? rd_data : '0;
    end
    if (emit_step) begin
      out_pixel <= pix_next;
    end
  end

endmodule

`default_nettype wire
